[rtl/avw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avw_pkg: shared types and constants of the air/vacuum wavelength converter
// Register indexes, modes, status codes, datapath operations and the fixed
// dispersion coefficients of the direct conversion mode.
// ----------------------------------------------------------------------------
package avw_pkg;

    localparam int REG_W      = 40;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int STAT_W     = 2;
    localparam int PASS_OUT_W = 5;
    localparam int OP_W       = 4;

    localparam int MAX_PASSES_DEF = 30;
    localparam int WAVE_BITS_DEF  = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WMIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WMAX = 3'd7;

    // conversion modes
    localparam logic [MODE_W-1:0] MODE_V2A        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_A2V_ITER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_A2V_DIRECT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PASS       = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;
    localparam logic [STAT_W-1:0] ST_LIMIT = 2'd3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_SQ        = 4'd2;
    localparam logic [OP_W-1:0] OP_S         = 4'd3;
    localparam logic [OP_W-1:0] OP_T1        = 4'd4;
    localparam logic [OP_W-1:0] OP_T2        = 4'd5;
    localparam logic [OP_W-1:0] OP_AIR       = 4'd6;
    localparam logic [OP_W-1:0] OP_UPD       = 4'd7;
    localparam logic [OP_W-1:0] OP_DMUL      = 4'd8;
    localparam logic [OP_W-1:0] OP_RES_AIR   = 4'd9;
    localparam logic [OP_W-1:0] OP_RES_VAC   = 4'd10;
    localparam logic [OP_W-1:0] OP_RES_DIR   = 4'd11;
    localparam logic [OP_W-1:0] OP_RES_RANGE = 4'd12;
    localparam logic [OP_W-1:0] OP_RES_PASS  = 4'd13;

    // register reset values
    localparam logic [REG_W-1:0] WMIN_RESET = 40'd33554432000;
    localparam logic [REG_W-1:0] WMAX_RESET = 40'hFF_FFFF_FFFF;

    // 1e8 scaled by 2^80, numerator of s = 1e8 / w^2
    localparam logic [127:0] NUM_S = 128'd100000000 << 80;

    // fixed coefficients, rounded to nearest
    localparam logic [127:0] DIR_A_FULL =
        ((128'd8336624212083 << 40) + 128'd50000000000000000) / 128'd100000000000000000;
    localparam logic [127:0] DIR_B1_FULL =
        ((128'd2408926869968 << 40) + 128'd50000000000000) / 128'd100000000000000;
    localparam logic [127:0] DIR_C1_FULL =
        ((128'd1301065924522 << 32) + 128'd5000000000) / 128'd10000000000;
    localparam logic [127:0] DIR_B2_FULL =
        ((128'd1599740894897 << 40) + 128'd5000000000000000) / 128'd10000000000000000;
    localparam logic [127:0] DIR_C2_FULL =
        ((128'd3892568793293 << 32) + 128'd50000000000) / 128'd100000000000;

    localparam logic [REG_W-1:0] DIR_A  = DIR_A_FULL[REG_W-1:0];
    localparam logic [REG_W-1:0] DIR_B1 = DIR_B1_FULL[REG_W-1:0];
    localparam logic [REG_W-1:0] DIR_C1 = DIR_C1_FULL[REG_W-1:0];
    localparam logic [REG_W-1:0] DIR_B2 = DIR_B2_FULL[REG_W-1:0];
    localparam logic [REG_W-1:0] DIR_C2 = DIR_C2_FULL[REG_W-1:0];

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic              unit_busy;
        logic              range_bad;
        logic              conv;
        logic              pass_limit;
        logic [MODE_W-1:0] mode;
    } dp_stat_t;

endpackage

[rtl/avw_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avw_mul: 64 x 64 sequential multiplier
// Four 32 x 32 partial products, one per cycle, registered and accumulated.
// ----------------------------------------------------------------------------
module avw_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         busy,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sel_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [127:0] pp_sh;

    assign pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        unique case (sel_reg)
            2'd0:       pp_sh = {64'd0, pp_reg};
            2'd1, 2'd2: pp_sh = {32'd0, pp_reg, 32'd0};
            2'd3:       pp_sh = {pp_reg, 64'd0};
            default:    pp_sh = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg  <= pa * pb;
                sel_reg <= cnt_reg[1:0];
            end
            // add the product registered last cycle
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/avw_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avw_div: 128 / 128 restoring divider with saturated quotient
// One quotient bit per cycle; the quotient is clamped to a given limit.
// ----------------------------------------------------------------------------
module avw_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [127:0] den,
    input  logic [63:0]  lim,
    output logic         busy,
    output logic         done,
    output logic [63:0]  q_sat
);

    localparam int DW = 128;
    localparam int CW = $clog2(DW);

    logic [DW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [63:0]   lim_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, num_reg[DW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            lim_reg <= lim;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            num_reg <= {num_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], ge};
        end
    end

    assign q_sat = ((q_reg[DW-1:64] != '0) || (q_reg[63:0] > lim_reg)) ? lim_reg : q_reg[63:0];
    assign busy  = busy_reg;
    assign done  = done_reg;

endmodule

[rtl/avw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avw_dp: converter datapath
// Configuration registers, working registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module avw_dp #(
    parameter int MAX_PASSES = avw_pkg::MAX_PASSES_DEF,
    parameter int WAVE_BITS  = avw_pkg::WAVE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  avw_pkg::dp_cmd_t                    cmd,
    output avw_pkg::dp_stat_t                   stat,
    input  logic                                cfg_we,
    input  logic [avw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [avw_pkg::REG_W-1:0]           cfg_data,
    input  logic [WAVE_BITS-1:0]                wavelength_in,
    output logic [WAVE_BITS-1:0]                wavelength_out,
    output logic [avw_pkg::STAT_W-1:0]         status,
    output logic [avw_pkg::PASS_OUT_W-1:0]     passes_used
);

    localparam int WB       = WAVE_BITS;
    localparam int PW       = $clog2(MAX_PASSES + 1);
    localparam int OUT_BITS = (WB < avw_pkg::REG_W) ? WB : avw_pkg::REG_W;
    localparam logic [WB-1:0] WMASK    = '1;
    localparam logic [WB-1:0] OUT_MASK = {WB{1'b1}} >> (WB - OUT_BITS);
    localparam logic signed [63:0] ONE_Q48  = 64'sd1 <<< 48;
    localparam logic signed [63:0] TERM_MAX = 64'sd1 <<< 60;

    // configuration registers
    logic [avw_pkg::MODE_W-1:0] mode_reg;
    logic [avw_pkg::REG_W-1:0]  a_reg, b1_reg, c1_reg, b2_reg, c2_reg;
    logic [avw_pkg::REG_W-1:0]  wmin_reg, wmax_reg;

    // working registers
    logic [WB-1:0]                w_reg;
    logic [WB-1:0]                x_reg;
    logic [WB-1:0]                air_reg;
    logic [WB-1:0]                res_reg;
    logic [avw_pkg::STAT_W-1:0]   code_reg;
    logic [avw_pkg::STAT_W-1:0]   range_reg;
    logic                         conv_reg;
    logic [PW-1:0]                pass_reg;
    logic [avw_pkg::PASS_OUT_W-1:0] pout_reg;
    logic [63:0]                  s_reg;
    logic signed [63:0]           n_reg;
    logic                         neg_reg;
    logic [avw_pkg::OP_W-1:0]     pend_reg;

    // unit connections
    logic         mul_start, mul_busy, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_prod;
    logic         div_start, div_busy, div_done;
    logic [127:0] div_num, div_den;
    logic [63:0]  div_lim, div_q;

    // index terms
    logic                       dir;
    logic [avw_pkg::REG_W-1:0]  ca, cb1, cc1, cb2, cc2, tb, tc;
    logic [63:0]                tc64, tdmag;
    logic                       tneg, tpole, tzero;
    logic signed [63:0]         n_base, pole_add, q_signed;

    // iteration update
    logic signed [WB:0]   delta;
    logic signed [WB+1:0] vac_n;
    logic [WB-1:0]        vac_clamp;
    logic                 delta_small;
    logic [63:0]          w_ext;
    logic [31:0]          pass_ext;
    logic [PW-1:0]        pass_inc;
    logic [WB-1:0]        dir_res;

    assign dir = mode_reg == avw_pkg::MODE_A2V_DIRECT;
    assign ca  = dir ? avw_pkg::DIR_A  : a_reg;
    assign cb1 = dir ? avw_pkg::DIR_B1 : b1_reg;
    assign cc1 = dir ? avw_pkg::DIR_C1 : c1_reg;
    assign cb2 = dir ? avw_pkg::DIR_B2 : b2_reg;
    assign cc2 = dir ? avw_pkg::DIR_C2 : c2_reg;

    assign tb    = (cmd.op == avw_pkg::OP_T1) ? cb1 : cb2;
    assign tc    = (cmd.op == avw_pkg::OP_T1) ? cc1 : cc2;
    assign tc64  = {24'd0, tc};
    assign tneg  = tc64 < s_reg;
    assign tdmag = tneg ? (s_reg - tc64) : (tc64 - s_reg);
    assign tzero = tb == '0;
    assign tpole = tdmag == '0;

    assign n_base   = ONE_Q48 + $signed({16'd0, ca, 8'd0});
    assign pole_add = (!tzero && tpole) ? TERM_MAX : 64'sd0;
    assign q_signed = neg_reg ? -$signed(div_q) : $signed(div_q);

    assign delta       = $signed({1'b0, air_reg}) - $signed({1'b0, w_reg});
    assign vac_n       = $signed({2'b00, x_reg}) - $signed({delta[WB], delta});
    assign delta_small = (delta == '0) || (delta == (WB+1)'(1)) || (delta == '1);
    assign vac_clamp   = vac_n[WB+1] ? '0 : (vac_n[WB] ? WMASK : vac_n[WB-1:0]);

    assign w_ext    = 64'(wavelength_in);
    assign pass_inc = pass_reg + 1'b1;
    assign pass_ext = 32'(pass_reg);

    // direct mode: floor(w * n / 2^48), saturated; no positive index gives 0
    assign dir_res = (n_reg <= 64'sd0) ? '0 :
                     (((mul_prod[127:48] >> WB) != '0) ? WMASK : mul_prod[48 +: WB]);

    // unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = 64'(x_reg);
        mul_b     = 64'(x_reg);
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_lim   = '0;
        unique case (cmd.op)
            avw_pkg::OP_SQ:
            begin
                mul_start = 1'b1;
            end
            avw_pkg::OP_DMUL:
            begin
                mul_start = 1'b1;
                mul_b     = n_reg;
            end
            avw_pkg::OP_S:
            begin
                div_start = x_reg != '0;
                div_num   = avw_pkg::NUM_S;
                div_den   = mul_prod;
                div_lim   = '1;
            end
            avw_pkg::OP_T1, avw_pkg::OP_T2:
            begin
                div_start = !tzero && !tpole;
                div_num   = {48'd0, tb, 40'd0};
                div_den   = {64'd0, tdmag};
                div_lim   = TERM_MAX;
            end
            avw_pkg::OP_AIR:
            begin
                div_start = n_reg > 64'sd0;
                div_num   = 128'(x_reg) << 48;
                div_den   = {64'd0, n_reg};
                div_lim   = 64'(WMASK);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    avw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    avw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .lim   (div_lim),
        .busy  (div_busy),
        .done  (div_done),
        .q_sat (div_q)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= avw_pkg::MODE_V2A;
            a_reg    <= '0;
            b1_reg   <= '0;
            c1_reg   <= '0;
            b2_reg   <= '0;
            c2_reg   <= '0;
            wmin_reg <= avw_pkg::WMIN_RESET;
            wmax_reg <= avw_pkg::WMAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                avw_pkg::CFG_MODE: mode_reg <= cfg_data[avw_pkg::MODE_W-1:0];
                avw_pkg::CFG_A:    a_reg    <= cfg_data;
                avw_pkg::CFG_B1:   b1_reg   <= cfg_data;
                avw_pkg::CFG_C1:   c1_reg   <= cfg_data;
                avw_pkg::CFG_B2:   b2_reg   <= cfg_data;
                avw_pkg::CFG_C2:   c2_reg   <= cfg_data;
                avw_pkg::CFG_WMIN: wmin_reg <= cfg_data;
                avw_pkg::CFG_WMAX: wmax_reg <= cfg_data;
                default:           mode_reg <= mode_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            unique case (pend_reg)
                avw_pkg::OP_S:                s_reg   <= div_q;
                avw_pkg::OP_T1, avw_pkg::OP_T2: n_reg <= n_reg + q_signed;
                avw_pkg::OP_AIR:              air_reg <= div_q[WB-1:0];
                default:                      air_reg <= air_reg;
            endcase
        end
        unique case (cmd.op)
            avw_pkg::OP_LOAD:
            begin
                w_reg    <= wavelength_in;
                x_reg    <= wavelength_in;
                pass_reg <= '0;
                conv_reg <= 1'b0;
                if (w_ext < 64'(wmin_reg))
                    range_reg <= avw_pkg::ST_BELOW;
                else if (w_ext > 64'(wmax_reg))
                    range_reg <= avw_pkg::ST_ABOVE;
                else
                    range_reg <= avw_pkg::ST_OK;
            end
            avw_pkg::OP_S:
            begin
                pend_reg <= cmd.op;
                if (x_reg == '0)
                    s_reg <= '1;
            end
            avw_pkg::OP_T1:
            begin
                pend_reg <= cmd.op;
                neg_reg  <= tneg;
                n_reg    <= n_base + pole_add;
            end
            avw_pkg::OP_T2:
            begin
                pend_reg <= cmd.op;
                neg_reg  <= tneg;
                n_reg    <= n_reg + pole_add;
            end
            avw_pkg::OP_AIR:
            begin
                pend_reg <= cmd.op;
                if (n_reg <= 64'sd0)
                    air_reg <= WMASK;
            end
            avw_pkg::OP_UPD:
            begin
                x_reg    <= vac_clamp;
                conv_reg <= delta_small;
                pass_reg <= pass_inc;
            end
            avw_pkg::OP_RES_AIR:
            begin
                res_reg  <= air_reg & OUT_MASK;
                code_reg <= avw_pkg::ST_OK;
                pout_reg <= '0;
            end
            avw_pkg::OP_RES_VAC:
            begin
                res_reg  <= x_reg & OUT_MASK;
                code_reg <= conv_reg ? avw_pkg::ST_OK : avw_pkg::ST_LIMIT;
                pout_reg <= (pass_ext > 32'd31) ? 5'd31 : pass_ext[4:0];
            end
            avw_pkg::OP_RES_DIR:
            begin
                res_reg  <= dir_res & OUT_MASK;
                code_reg <= avw_pkg::ST_OK;
                pout_reg <= '0;
            end
            avw_pkg::OP_RES_RANGE:
            begin
                res_reg  <= '0;
                code_reg <= range_reg;
                pout_reg <= '0;
            end
            avw_pkg::OP_RES_PASS:
            begin
                res_reg  <= w_reg & OUT_MASK;
                code_reg <= avw_pkg::ST_OK;
                pout_reg <= '0;
            end
            default:
            begin
                pend_reg <= pend_reg;
            end
        endcase
    end

    assign stat.unit_busy  = mul_busy | mul_done | div_busy | div_done;
    assign stat.range_bad  = range_reg != avw_pkg::ST_OK;
    assign stat.conv       = conv_reg;
    assign stat.pass_limit = pass_reg == PW'(MAX_PASSES);
    assign stat.mode       = mode_reg;

    assign wavelength_out = res_reg;
    assign status         = code_reg;
    assign passes_used    = pout_reg;

endmodule

[rtl/avw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avw_ctrl: converter sequencer
// Steps the datapath through the range check, index evaluation, conversion and iteration.
// ----------------------------------------------------------------------------
module avw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output avw_pkg::dp_cmd_t  cmd,
    input  avw_pkg::dp_stat_t stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_S    = 4'd3;
    localparam logic [3:0] S_T1   = 4'd4;
    localparam logic [3:0] S_T2   = 4'd5;
    localparam logic [3:0] S_AIR  = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DMUL = 4'd8;
    localparam logic [3:0] S_RAIR = 4'd9;
    localparam logic [3:0] S_RVAC = 4'd10;
    localparam logic [3:0] S_RDIR = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       issued_reg, issued_next;
    logic [avw_pkg::OP_W-1:0] op_st;
    logic [3:0] succ;

    // operation and successor of each step
    always_comb
    begin
        unique case (state_reg)
            S_SQ:   begin op_st = avw_pkg::OP_SQ;   succ = S_S;  end
            S_S:    begin op_st = avw_pkg::OP_S;    succ = S_T1; end
            S_T1:   begin op_st = avw_pkg::OP_T1;   succ = S_T2; end
            S_T2:
            begin
                op_st = avw_pkg::OP_T2;
                succ  = (stat.mode == avw_pkg::MODE_A2V_DIRECT) ? S_DMUL : S_AIR;
            end
            S_AIR:
            begin
                op_st = avw_pkg::OP_AIR;
                succ  = (stat.mode == avw_pkg::MODE_A2V_ITER) ? S_UPD : S_RAIR;
            end
            S_UPD:
            begin
                op_st = avw_pkg::OP_UPD;
                succ  = (stat.conv || stat.pass_limit) ? S_RVAC : S_SQ;
            end
            S_DMUL: begin op_st = avw_pkg::OP_DMUL;    succ = S_RDIR; end
            S_RAIR: begin op_st = avw_pkg::OP_RES_AIR; succ = S_DONE; end
            S_RVAC: begin op_st = avw_pkg::OP_RES_VAC; succ = S_DONE; end
            S_RDIR: begin op_st = avw_pkg::OP_RES_DIR; succ = S_DONE; end
            default: begin op_st = avw_pkg::OP_NONE;   succ = S_IDLE; end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        cmd.op      = avw_pkg::OP_NONE;
        priority if (state_reg == S_IDLE)
        begin
            if (start)
            begin
                cmd.op     = avw_pkg::OP_LOAD;
                state_next = S_CHK;
            end
        end
        else if (state_reg == S_CHK)
        begin
            if (stat.range_bad)
            begin
                cmd.op     = avw_pkg::OP_RES_RANGE;
                state_next = S_DONE;
            end
            else if (stat.mode == avw_pkg::MODE_PASS)
            begin
                cmd.op     = avw_pkg::OP_RES_PASS;
                state_next = S_DONE;
            end
            else
            begin
                state_next = S_SQ;
            end
        end
        else if (state_reg == S_DONE)
        begin
            state_next = S_IDLE;
        end
        else if (!issued_reg)
        begin
            cmd.op      = op_st;
            issued_next = 1'b1;
        end
        else if (!stat.unit_busy)
        begin
            issued_next = 1'b0;
            state_next  = succ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.unit_busy |-> busy)
        else $error("arithmetic unit active while sequencer idle");

endmodule

[rtl/air_vacuum_wavelength_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_vacuum_wavelength_converter: air / vacuum wavelength conversion
// Edlen-type index n = 1 + a + b1/(c1-s) + b2/(c2-s), s = 1e8/w^2, applied
// as vacuum to air, iterative air to vacuum, or direct air to vacuum.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive wavelength_in and raise start; the word is taken on a clock
//   edge where start is high and busy is low. busy stays high until the
//   result has been presented.
//   Output: done is high for exactly one cycle with wavelength_out, status
//   and passes_used valid. The receiver cannot stall; grab the word then.
//   Configuration: cfg_valid with cfg_index/cfg_data writes one register;
//   cfg_ready is always high. Write only while busy is low.
// Sequence (one word at a time): an out of range word or pass-through mode
//   presents its result straight from the range check. Each other step
//   issues its operation, waits while its unit runs and signals done, then
//   advances; the square is 4 partial products plus the final add. One
//   index evaluation is the square, s and two pole terms. Vacuum to air and
//   direct mode follow it with the air division or the final multiply;
//   iterative mode repeats evaluation, air division and update per pass
//   until it converges or reaches MAX_PASSES. A zero wavelength, a zero
//   numerator, a pole hit or an index that is not positive skips its
//   division. A further word is taken once busy is low again after the
//   result.
// Reset: asynchronous, active low; configuration registers take their default
//   values and the sequencer returns to idle; working registers are not reset.
// ----------------------------------------------------------------------------
module air_vacuum_wavelength_converter #(
    parameter int MAX_PASSES = avw_pkg::MAX_PASSES_DEF,
    parameter int WAVE_BITS  = avw_pkg::WAVE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input word
    input  logic                            start,
    output logic                            busy,
    input  logic [WAVE_BITS-1:0]            wavelength_in,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [avw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [avw_pkg::REG_W-1:0]       cfg_data,
    // result word
    output logic                            done,
    output logic [WAVE_BITS-1:0]            wavelength_out,
    output logic [avw_pkg::STAT_W-1:0]      status,
    output logic [avw_pkg::PASS_OUT_W-1:0]  passes_used
);

    avw_pkg::dp_cmd_t  cmd;
    avw_pkg::dp_stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: walks the conversion steps and raises done
    avw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // datapath: registers, shared multiplier and divider, result hold
    avw_dp #(
        .MAX_PASSES (MAX_PASSES),
        .WAVE_BITS  (WAVE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .wavelength_in  (wavelength_in),
        .wavelength_out (wavelength_out),
        .status         (status),
        .passes_used    (passes_used)
    );

endmodule
